// File: hdl/plist_pkg.sv
// plist_pkg: shared types and constants for the positional list engine
// no dependencies; imported by every module of the block

package plist_pkg;

  localparam int DATA_W       = 32;
  localparam int CMD_W        = 2;
  localparam int POS_W        = 7;
  localparam int STATUS_W     = 2;
  localparam int LEN_W        = 7;
  localparam int CAPACITY_DEF = 64;
  // taps or-ed together in one registered group of the read-out tree
  localparam int GROUP_SIZE   = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_READ   = 2'd2
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // broadcast to every cell in the cycle a command is taken
  typedef struct packed {
    logic              ins;    // successful insert
    logic              del;    // successful delete
    logic              rd;     // successful delete or read: tap the entry
    logic [POS_W-1:0]  pos;
    logic [DATA_W-1:0] value;
  } cell_ctl_t;

  // result fields that travel beside the read-out tree
  typedef struct packed {
    status_t          status;
    logic [LEN_W-1:0] length;
  } meta_t;

endpackage

// File: hdl/plist_cell.sv
// plist_cell: one list entry, shifts with its neighbors on insert and delete
// depends on plist_pkg

module plist_cell import plist_pkg::*; #(
  parameter int IDX = 0,
  parameter int IW  = POS_W
) (
  input  logic              clk,
  input  cell_ctl_t         ctl,
  input  logic [DATA_W-1:0] left_data,
  input  logic [DATA_W-1:0] right_data,
  output logic [DATA_W-1:0] data,
  output logic [DATA_W-1:0] tap
);

  localparam logic [IW-1:0] ME = IW'(IDX);

  logic [DATA_W-1:0] data_r;
  logic [DATA_W-1:0] tap_r;
  logic [IW-1:0]     pos_ext;

  assign pos_ext = IW'(ctl.pos);

  // entry update: take the new value, the left neighbor or the right neighbor
  always_ff @(posedge clk) begin
    if (ctl.ins) begin
      if (ME == pos_ext) begin
        data_r <= ctl.value;
      end else if (ME > pos_ext) begin
        data_r <= left_data;
      end
    end else if (ctl.del && (ME >= pos_ext)) begin
      data_r <= right_data;
    end
  end

  // read tap holds the entry before the shift, zero when not selected
  always_ff @(posedge clk) begin
    if (ctl.rd && (ME == pos_ext)) begin
      tap_r <= data_r;
    end else begin
      tap_r <= '0;
    end
  end

  assign data = data_r;
  assign tap  = tap_r;

endmodule

// File: hdl/plist_collect.sv
// plist_collect: registered or-tree that gathers the selected cell tap
// depends on plist_pkg; fed by the cell row of the top level

module plist_collect import plist_pkg::*; #(
  parameter int NT = CAPACITY_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       tap_vld,
  input  meta_t                      tap_meta,
  input  logic [DATA_W-1:0]          taps [NT],
  output logic                       out_strobe,
  output logic [STATUS_W-1:0]        out_status,
  output logic signed [DATA_W-1:0]   out_result_value,
  output logic [LEN_W-1:0]           out_list_length
);

  localparam int NG = (NT + GROUP_SIZE - 1) / GROUP_SIZE;

  logic [DATA_W-1:0] taps_pad [NG*GROUP_SIZE];
  logic [DATA_W-1:0] grp_nxt  [NG];
  logic [DATA_W-1:0] grp_r    [NG];
  logic [DATA_W-1:0] all_nxt;
  logic              vld1_r;
  meta_t             meta1_r;
  logic              strobe_r;
  meta_t             meta2_r;
  logic [DATA_W-1:0] value_r;

  // pad the tap row to whole groups
  for (genvar t = 0; t < NG*GROUP_SIZE; t++) begin : g_pad
    if (t < NT) begin : g_real
      assign taps_pad[t] = taps[t];
    end else begin : g_zero
      assign taps_pad[t] = '0;
    end
  end

  // first level: or within each group
  always_comb begin
    for (int g = 0; g < NG; g++) begin
      grp_nxt[g] = '0;
      for (int t = 0; t < GROUP_SIZE; t++) begin
        grp_nxt[g] = grp_nxt[g] | taps_pad[g*GROUP_SIZE + t];
      end
    end
  end

  // second level: or across groups
  always_comb begin
    all_nxt = '0;
    for (int g = 0; g < NG; g++) begin
      all_nxt = all_nxt | grp_r[g];
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    grp_r   <= grp_nxt;
    meta1_r <= tap_meta;
    meta2_r <= meta1_r;
    value_r <= all_nxt;
  end

  // strobe pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r   <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      vld1_r   <= tap_vld;
      strobe_r <= vld1_r;
    end
  end

  assign out_strobe       = strobe_r;
  assign out_status       = meta2_r.status;
  assign out_result_value = value_r;
  assign out_list_length  = meta2_r.length;

endmodule

// File: hdl/positional_list_engine.sv
// positional_list_engine: ordered list with insert, delete and read at a position
// result path: registered through the cell tap, the group or and the final or
// throughput: one command per cycle while busy is low; every cell shifts in parallel from an index compare
// busy is high during reset and in the cycle after it; the receiver cannot stall results
// reset (rst_n, synchronous): list length 0, result pipeline empty, entries left as is
// depends on plist_pkg, plist_cell, plist_collect

module positional_list_engine import plist_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [CMD_W-1:0]         in_command,
  input  logic [POS_W-1:0]         in_position,
  input  logic signed [DATA_W-1:0] in_value,
  output logic                     out_strobe,
  output logic [STATUS_W-1:0]      out_status,
  output logic signed [DATA_W-1:0] out_result_value,
  output logic [LEN_W-1:0]         out_list_length
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = (CW > POS_W) ? CW : POS_W;

  logic              busy_r;
  logic              accept;
  logic [CW-1:0]     cnt_r;
  logic [CW-1:0]     cnt_nxt;
  logic [IW-1:0]     pos_w;
  logic [IW-1:0]     cnt_w;
  logic              full;
  status_t           status;
  cell_ctl_t         ctl;
  meta_t             meta0_r;
  logic              vld0_r;
  logic [DATA_W-1:0] cell_data [CAPACITY];
  logic [DATA_W-1:0] cell_tap  [CAPACITY];

  assign accept = start && !busy_r;
  assign pos_w  = IW'(in_position);
  assign cnt_w  = IW'(cnt_r);
  assign full   = (cnt_r == CW'(CAPACITY));

  // command decode and range checks
  always_comb begin
    status = ST_RANGE;
    unique case (in_command) inside
      CMD_INSERT: begin
        if (full) begin
          status = ST_FULL;
        end else if (pos_w <= cnt_w) begin
          status = ST_OK;
        end
      end
      CMD_DELETE, CMD_READ: begin
        if (pos_w < cnt_w) begin
          status = ST_OK;
        end
      end
      default: status = ST_RANGE;
    endcase
  end

  // broadcast controls for the cell row
  always_comb begin
    ctl.ins   = accept && (status == ST_OK) && (in_command == CMD_INSERT);
    ctl.del   = accept && (status == ST_OK) && (in_command == CMD_DELETE);
    ctl.rd    = accept && (status == ST_OK) &&
                ((in_command == CMD_DELETE) || (in_command == CMD_READ));
    ctl.pos   = in_position;
    ctl.value = in_value;
  end

  // length after the command
  always_comb begin
    cnt_nxt = cnt_r;
    if (ctl.ins) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (ctl.del) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
      vld0_r <= 1'b0;
    end else begin
      busy_r <= 1'b0;
      cnt_r  <= cnt_nxt;
      vld0_r <= accept;
    end
  end

  // result fields that wait beside the cell taps
  always_ff @(posedge clk) begin
    meta0_r.status <= status;
    meta0_r.length <= LEN_W'(IW'(cnt_nxt));
  end

  // row of cells, each handing its entry to both neighbors
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] left_d;
    logic [DATA_W-1:0] right_d;
    if (i == 0) begin : g_first
      assign left_d = cell_data[i];
    end else begin : g_mid_l
      assign left_d = cell_data[i-1];
    end
    if (i == CAPACITY-1) begin : g_last
      assign right_d = cell_data[i];
    end else begin : g_mid_r
      assign right_d = cell_data[i+1];
    end
    plist_cell #(
      .IDX (i),
      .IW  (IW)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .left_data  (left_d),
      .right_data (right_d),
      .data       (cell_data[i]),
      .tap        (cell_tap[i])
    );
  end

  // gather the selected entry and drive the result
  plist_collect #(
    .NT (CAPACITY)
  ) u_collect (
    .clk              (clk),
    .rst_n            (rst_n),
    .tap_vld          (vld0_r),
    .tap_meta         (meta0_r),
    .taps             (cell_tap),
    .out_strobe       (out_strobe),
    .out_status       (out_status),
    .out_result_value (out_result_value),
    .out_list_length  (out_list_length)
  );

  assign busy = busy_r;

  // checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(CAPACITY))
    else $error("list length above capacity");

  a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(accept, 3))
    else $error("result without an accepted command");

  a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_status == ST_FULL)) |-> (out_list_length == LEN_W'(CAPACITY)))
    else $error("full status with list not at capacity");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_status != ST_OK)) |-> (out_result_value == '0))
    else $error("failed command returned a value");

  a_len_step: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_command == CMD_READ)) |=> (cnt_r == $past(cnt_r)))
    else $error("read changed the list length");

endmodule

// File: bench/positional_list_engine_tb.sv
`timescale 1ns / 100ps
// positional_list_engine_tb: self-checking bench for the positional list engine
// directed and random list commands, checked against an in-bench list predictor
// depends on plist_pkg and positional_list_engine

module positional_list_engine_tb;
  import plist_pkg::*;

  localparam int LIST_CAP = CAPACITY_DEF;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int RANDOM_PER_PHASE = 285;
  localparam int MIX_STRETCH = 40;
  localparam int DRAIN_CYCLES = 12;
  localparam int MAX_REPORTS = 10;
  localparam int NUM_PHASES = 4;

  // bias of the random command mix
  typedef enum int {
    MIX_FILL,
    MIX_DRAIN,
    MIX_EVEN
  } mix_t;

  typedef struct packed {
    logic [CMD_W-1:0]         command;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value;
  } list_cmd_t;

  typedef struct packed {
    status_t                  status;
    logic signed [DATA_W-1:0] value;
    logic [LEN_W-1:0]         length;
  } list_result_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  logic [CMD_W-1:0]         in_command = '0;
  logic [POS_W-1:0]         in_position = '0;
  logic signed [DATA_W-1:0] in_value = '0;
  logic                     out_strobe;
  logic [STATUS_W-1:0]      out_status;
  logic signed [DATA_W-1:0] out_result_value;
  logic [LEN_W-1:0]         out_list_length;

  positional_list_engine #(
    .CAPACITY(LIST_CAP)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_command      (in_command),
    .in_position     (in_position),
    .in_value        (in_value),
    .out_strobe      (out_strobe),
    .out_status      (out_status),
    .out_result_value(out_result_value),
    .out_list_length (out_list_length)
  );

  list_cmd_t                cmd_backlog[$];
  list_result_t             pending_results[$];
  logic signed [DATA_W-1:0] list_shadow[$];
  int                       plan_len = 0;
  int                       idle_pct = 0;
  bit                       took = 1'b0;
  int                       mismatches = 0;
  int                       ok_inserts = 0;
  int                       ok_deletes = 0;
  int                       ok_reads = 0;
  int                       range_hits = 0;
  int                       full_hits = 0;
  int                       peak_len = 0;
  int                       phase_idle[NUM_PHASES] = '{0, 63, 0, 34};

  initial begin
    forever #5 clk = ~clk;
  end

  // expected outcome of one command; updates the shadow list
  function automatic list_result_t apply_list_command(list_cmd_t c);
    list_result_t r;
    int p;
    p = int'(c.position);
    r.status = ST_RANGE;
    r.value = '0;
    case (c.command)
      CMD_INSERT: begin
        if (list_shadow.size() >= LIST_CAP) begin
          r.status = ST_FULL;
        end else if (p <= list_shadow.size()) begin
          list_shadow.insert(p, c.value);
          r.status = ST_OK;
        end
      end
      CMD_DELETE: begin
        if (p < list_shadow.size()) begin
          r.value = list_shadow[p];
          list_shadow.delete(p);
          r.status = ST_OK;
        end
      end
      CMD_READ: begin
        if (p < list_shadow.size()) begin
          r.value = list_shadow[p];
          r.status = ST_OK;
        end
      end
      default: ;
    endcase
    r.length = LEN_W'(list_shadow.size());
    return r;
  endfunction

  // queue one command and keep the planned length in step
  task automatic queue_cmd(logic [CMD_W-1:0] cmd, int pos, logic signed [DATA_W-1:0] val);
    list_cmd_t c;
    c.command = cmd;
    c.position = POS_W'(pos);
    c.value = val;
    cmd_backlog.push_back(c);
    if (cmd == CMD_INSERT && plan_len < LIST_CAP && pos <= plan_len) begin
      plan_len++;
    end else if (cmd == CMD_DELETE && pos < plan_len) begin
      plan_len--;
    end
  endtask

  function automatic logic signed [DATA_W-1:0] random_word();
    case ($urandom_range(7))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'hffff_ffff;
      3: return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  // mostly legal positions, with the edges and some noise
  task automatic queue_random_cmd(mix_t mix);
    int roll;
    int ins_pct;
    int del_pct;
    int pos;
    logic [CMD_W-1:0] cmd;
    case (mix)
      MIX_FILL: begin
        ins_pct = 65;
        del_pct = 15;
      end
      MIX_DRAIN: begin
        ins_pct = 15;
        del_pct = 65;
      end
      default: begin
        ins_pct = 35;
        del_pct = 35;
      end
    endcase
    roll = $urandom_range(99);
    if (roll < 3) begin
      cmd = CMD_UNUSED;
    end else if (roll < 3 + ins_pct) begin
      cmd = CMD_INSERT;
    end else if (roll < 3 + ins_pct + del_pct) begin
      cmd = CMD_DELETE;
    end else begin
      cmd = CMD_READ;
    end
    roll = $urandom_range(99);
    if (roll < 80) begin
      if (cmd == CMD_INSERT) begin
        pos = $urandom_range(plan_len);
      end else if (plan_len > 0) begin
        pos = $urandom_range(plan_len - 1);
      end else begin
        pos = 0;
      end
    end else if (roll < 90) begin
      pos = plan_len + $urandom_range(1);
    end else begin
      pos = $urandom_range((1 << POS_W) - 1);
    end
    queue_cmd(cmd, pos, random_word());
  endtask

  // driver: present the head of the backlog, hold it until the transfer
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || took) begin
      took = 1'b0;
      if (cmd_backlog.size() != 0 && $urandom_range(99) >= idle_pct) begin
        start <= 1'b1;
        in_command <= cmd_backlog[0].command;
        in_position <= cmd_backlog[0].position;
        in_value <= cmd_backlog[0].value;
      end else begin
        start <= 1'b0;
        in_command <= CMD_W'($urandom);
        in_position <= POS_W'($urandom);
        in_value <= $urandom;
      end
    end
  end

  // command transfer: predict from the sampled ports
  always @(posedge clk) begin : take_command
    list_cmd_t c;
    list_result_t r;
    if (rst_n && start && !busy) begin
      took = 1'b1;
      c.command = in_command;
      c.position = in_position;
      c.value = in_value;
      void'(cmd_backlog.pop_front());
      r = apply_list_command(c);
      pending_results.push_back(r);
      if (r.status == ST_FULL) begin
        full_hits++;
      end else if (r.status == ST_RANGE) begin
        range_hits++;
      end else if (c.command == CMD_INSERT) begin
        ok_inserts++;
      end else if (c.command == CMD_DELETE) begin
        ok_deletes++;
      end else begin
        ok_reads++;
      end
      if (list_shadow.size() > peak_len) begin
        peak_len = list_shadow.size();
      end
    end
  end

  // monitor: each result transfer against the oldest expectation
  always @(posedge clk) begin : check_results
    list_result_t want;
    if (rst_n && out_strobe !== 1'b0) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("unexpected result: status %0d value %0d length %0d",
                   out_status, out_result_value, out_list_length);
        end
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status || out_result_value !== want.value ||
            out_list_length !== want.length) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("mismatch: status %0d/%0d value %0d/%0d length %0d/%0d (exp/got)",
                     want.status, out_status, want.value, out_result_value,
                     want.length, out_list_length);
          end
        end
      end
    end
  end

  // stimulus and end of run
  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // empty list edges, unused code, extreme values, append and middle inserts
    queue_cmd(CMD_READ, 0, 32'h1234_5678);
    queue_cmd(CMD_DELETE, 0, 32'h0);
    queue_cmd(CMD_INSERT, 1, 32'h7);
    queue_cmd(CMD_UNUSED, 0, 32'h9);
    queue_cmd(CMD_INSERT, 0, 32'h7fff_ffff);
    queue_cmd(CMD_INSERT, 0, 32'h8000_0000);
    queue_cmd(CMD_INSERT, 2, 32'hffff_ffff);
    queue_cmd(CMD_INSERT, 1, 32'h0000_0000);
    queue_cmd(CMD_INSERT, 127, 32'h5);
    queue_cmd(CMD_INSERT, 4, 32'h5555_aaaa);
    queue_cmd(CMD_READ, 0, 32'h0);
    queue_cmd(CMD_READ, 1, 32'h0);
    queue_cmd(CMD_READ, 2, 32'h0);
    queue_cmd(CMD_READ, 3, 32'h0);
    queue_cmd(CMD_READ, 4, 32'h0);
    queue_cmd(CMD_READ, 5, 32'h0);
    queue_cmd(CMD_READ, 127, 32'h0);
    queue_cmd(CMD_DELETE, 2, 32'haaaa_5555);
    queue_cmd(CMD_DELETE, 4, 32'h0);
    queue_cmd(CMD_DELETE, 0, 32'h0);
    queue_cmd(CMD_UNUSED, 1, 32'h0);
    queue_cmd(CMD_READ, 2, 32'h0);

    // random phases with different sender idling
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      idle_pct = phase_idle[ph];
      for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
        queue_random_cmd(mix_t'((i / MIX_STRETCH) % 3));
      end
      while (cmd_backlog.size() != 0) @(posedge clk);
    end

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    mismatches += pending_results.size();

    $display("ran %0d inserts, %0d deletes, %0d reads that succeeded", ok_inserts,
             ok_deletes, ok_reads);
    $display("%0d out-of-range and %0d full refusals; longest list %0d of %0d",
             range_hits, full_hits, peak_len, LIST_CAP);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
